### rtl/bgpw_pkg.sv
// Shared types, constants and constant tables of the bitmap glyph pixel writer.
// Holds the font and spacing ROMs as functions; depends on nothing.
package bgpw_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int GLYPH_ROWS    = 8;
  localparam int GLYPH_COLS    = 8;
  localparam int FRAME_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int CURSOR_X_MAX  = 1023;

  localparam int CX_W   = 10;
  localparam int CY_W   = 8;
  localparam int CODE_W = 8;
  localparam int COL_W  = 8;
  localparam int ADDR_W = 18;
  localparam int WID_W  = 4;
  localparam int ROW_W  = $clog2(GLYPH_ROWS);
  localparam int CIDX_W = $clog2(GLYPH_COLS);
  localparam int GLYPH_W = GLYPH_ROWS * GLYPH_COLS;
  // largest linear offset: cursor at its limits plus the glyph extent
  localparam int OFF_MAX = SCREEN_WIDTH * ((1 << CY_W) - 1 + GLYPH_ROWS) + CURSOR_X_MAX
                           + GLYPH_COLS;
  localparam int OFF_W  = $clog2(OFF_MAX + 1);

  localparam logic KIND_CURSOR = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  localparam int REG_W         = 32;
  localparam int PADDR_W       = 3;
  localparam logic REG_FG_COLOR = 1'b0;
  localparam logic REG_BUF_SEL  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] char_code;
    logic [CX_W-1:0]   pos_x;
    logic [CY_W-1:0]   pos_y;
  } cmd_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [COL_W-1:0]  color;
    logic              last;
  } pix_item_t;

  typedef struct packed {
    logic load;        // take a draw command
    logic set_cursor;  // take a cursor move
    logic advance;     // step the scan position
    logic capture;     // hold the current hit as pending
    logic push;        // transfer pending as a non-final write
    logic push_last;   // transfer pending as the final write
  } dp_cmd_t;

  typedef struct packed {
    logic in_width_zero;
    logic hit;
    logic at_end;
    logic pend_valid;
    logic can_push;
  } dp_status_t;

  // Spacing ROM, sixteen nibbles per line, first code in the top nibble.
  function automatic logic [WID_W-1:0] width_lookup(input logic [CODE_W-1:0] code);
    logic [16*WID_W-1:0] line;
    case (code[7:4])
      4'h0: line = 64'h8888888888888288;
      4'h1: line = 64'h8888888888888888;
      4'h2: line = 64'h3468888555874738;
      4'h3: line = 64'h8788888888346767;
      4'h4: line = 64'h8888888888888888;
      4'h5: line = 64'h8888888888858588;
      4'h6: line = 64'h4888888885885888;
      4'h7: line = 64'h8888788888873788;
      4'h8: line = 64'h8888888888888888;
      4'h9: line = 64'h8888888888888888;
      default: line = '0;
    endcase
    return line[{~code[3:0], 2'b00} +: WID_W];
  endfunction

  // Font ROM: top row in the top byte, leftmost pixel in the top bit of each byte.
  function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      8'd1:   g = 64'h7E81A581BDBD817E;
      8'd2:   g = 64'h7EFFDBFFC3C3FF7E;
      8'd3:   g = 64'h6CFEFEFE7C381000;
      8'd4:   g = 64'h10387CFE7C381000;
      8'd5:   g = 64'h387C38FEFE10107C;
      8'd6:   g = 64'h00183C7EFF7E187E;
      8'd7:   g = 64'h0000183C3C180000;
      8'd8:   g = 64'hFFFFE7C3C3E7FFFF;
      8'd9:   g = 64'h003C664242663C00;
      8'd10:  g = 64'hFFC399BDBD99C3FF;
      8'd11:  g = 64'h0F070F7DCCCCCC78;
      8'd12:  g = 64'h3C6666663C187E18;
      8'd13:  g = 64'h3F333F303070F0E0;
      8'd14:  g = 64'h7F637F636367E6C0;
      8'd15:  g = 64'h995A3CE7E73C5A99;
      8'd16:  g = 64'h80E0F8FEF8E08000;
      8'd17:  g = 64'h020E3EFE3E0E0200;
      8'd18:  g = 64'h183C7E18187E3C18;
      8'd19:  g = 64'h6666666666006600;
      8'd20:  g = 64'h7FDBDB7B1B1B1B00;
      8'd21:  g = 64'h3F607C66663E06FC;
      8'd22:  g = 64'h000000007E7E7E00;
      8'd23:  g = 64'h183C7E187E3C18FF;
      8'd24:  g = 64'h183C7E1818181800;
      8'd25:  g = 64'h181818187E3C1800;
      8'd26:  g = 64'h00180CFE0C180000;
      8'd27:  g = 64'h003060FE60300000;
      8'd28:  g = 64'h0000C0C0C0FE0000;
      8'd29:  g = 64'h002466FF66240000;
      8'd30:  g = 64'h00183C7EFFFF0000;
      8'd31:  g = 64'h00FFFF7E3C180000;
      8'd33:  g = 64'hC0C0C0C0C000C000;
      8'd34:  g = 64'hD8D8D80000000000;
      8'd35:  g = 64'h6C6CFE6CFE6C6C00;
      8'd36:  g = 64'h187EC07C06FC1800;
      8'd37:  g = 64'h00C6CC183066C600;
      8'd38:  g = 64'h386C3876DCCC7600;
      8'd39:  g = 64'h3030600000000000;
      8'd40:  g = 64'h3060C0C0C0603000;
      8'd41:  g = 64'hC06030303060C000;
      8'd42:  g = 64'h00663CFF3C660000;
      8'd43:  g = 64'h003030FCFC303000;
      8'd44:  g = 64'h00000000006060C0;
      8'd45:  g = 64'h000000FC00000000;
      8'd46:  g = 64'h0000000000C0C000;
      8'd47:  g = 64'h060C183060C08000;
      8'd48:  g = 64'h7CCEDEF6E6C67C00;
      8'd49:  g = 64'h307030303030FC00;
      8'd50:  g = 64'h7CC6067CC0C0FE00;
      8'd51:  g = 64'hFC06063C0606FC00;
      8'd52:  g = 64'h0CCCCCCCFE0C0C00;
      8'd53:  g = 64'hFEC0FC0606C67C00;
      8'd54:  g = 64'h7CC0C0FCC6C67C00;
      8'd55:  g = 64'hFE06060C18303000;
      8'd56:  g = 64'h7CC6C67CC6C67C00;
      8'd57:  g = 64'h7CC6C67E06067C00;
      8'd58:  g = 64'h00C0C00000C0C000;
      8'd59:  g = 64'h00606000006060C0;
      8'd60:  g = 64'h183060C060301800;
      8'd61:  g = 64'h0000FC00FC000000;
      8'd62:  g = 64'hC06030183060C000;
      8'd63:  g = 64'h78CC183030003000;
      8'd64:  g = 64'h7CC6DEDEDEC07E00;
      8'd65:  g = 64'h386CC6C6FEC6C600;
      8'd66:  g = 64'hFCC6C6FCC6C6FC00;
      8'd67:  g = 64'h7CC6C0C0C0C67C00;
      8'd68:  g = 64'hF8CCC6C6C6CCF800;
      8'd69:  g = 64'hFEC0C0F8C0C0FE00;
      8'd70:  g = 64'hFEC0C0F8C0C0C000;
      8'd71:  g = 64'h7CC6C0C0CEC67C00;
      8'd72:  g = 64'hC6C6C6FEC6C6C600;
      8'd73:  g = 64'h7E18181818187E00;
      8'd74:  g = 64'h0606060606C67C00;
      8'd75:  g = 64'hC6CCD8F0D8CCC600;
      8'd76:  g = 64'hC0C0C0C0C0C0FE00;
      8'd77:  g = 64'hC6EEFEFED6C6C600;
      8'd78:  g = 64'hC6E6F6DECEC6C600;
      8'd79:  g = 64'h7CC6C6C6C6C67C00;
      8'd80:  g = 64'hFCC6C6FCC0C0C000;
      8'd81:  g = 64'h7CC6C6C6D6DE7C06;
      8'd82:  g = 64'hFCC6C6FCD8CCC600;
      8'd83:  g = 64'h7CC6C07C06C67C00;
      8'd84:  g = 64'hFF18181818181800;
      8'd85:  g = 64'hC6C6C6C6C6C6FE00;
      8'd86:  g = 64'hC6C6C6C6C67C3800;
      8'd87:  g = 64'hC6C6C6C6D6FE6C00;
      8'd88:  g = 64'hC6C66C386CC6C600;
      8'd89:  g = 64'hC6C6C67C1830E000;
      8'd90:  g = 64'hFE060C183060FE00;
      8'd91:  g = 64'hF0C0C0C0C0C0F000;
      8'd92:  g = 64'hC06030180C060200;
      8'd93:  g = 64'hF03030303030F000;
      8'd94:  g = 64'h10386CC600000000;
      8'd95:  g = 64'h00000000000000FF;
      8'd96:  g = 64'hC0C0600000000000;
      8'd97:  g = 64'h00007C067EC67E00;
      8'd98:  g = 64'hC0C0C0FCC6C6FC00;
      8'd99:  g = 64'h00007CC6C0C67C00;
      8'd100: g = 64'h0606067EC6C67E00;
      8'd101: g = 64'h00007CC6FEC07C00;
      8'd102: g = 64'h1C36307830307800;
      8'd103: g = 64'h00007EC6C67E06FC;
      8'd104: g = 64'hC0C0FCC6C6C6C600;
      8'd105: g = 64'h6000E0606060F000;
      8'd106: g = 64'h060006060606C67C;
      8'd107: g = 64'hC0C0CCD8F8CCC600;
      8'd108: g = 64'hE06060606060F000;
      8'd109: g = 64'h0000CCFEFED6D600;
      8'd110: g = 64'h0000FCC6C6C6C600;
      8'd111: g = 64'h00007CC6C6C67C00;
      8'd112: g = 64'h0000FCC6C6FCC0C0;
      8'd113: g = 64'h00007EC6C67E0606;
      8'd114: g = 64'h0000FCC6C0C0C000;
      8'd115: g = 64'h00007EC07C06FC00;
      8'd116: g = 64'h3030FC3030301C00;
      8'd117: g = 64'h0000C6C6C6C67E00;
      8'd118: g = 64'h0000C6C6C67C3800;
      8'd119: g = 64'h0000C6C6D6FE6C00;
      8'd120: g = 64'h0000C66C386CC600;
      8'd121: g = 64'h0000C6C6C67E06FC;
      8'd122: g = 64'h0000FE0C3860FE00;
      8'd123: g = 64'h1C3030E030301C00;
      8'd124: g = 64'hC0C0C000C0C0C000;
      8'd125: g = 64'hE030301C3030E000;
      8'd126: g = 64'h76DC000000000000;
      8'd127: g = 64'h0010386CC6C6FE00;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

### rtl/bgpw_ctrl.sv
// Sequencer of the bitmap glyph pixel writer: command intake, glyph scan, final flush.
// Depends on bgpw_pkg; drives bgpw_dp through dp_cmd_t and reads dp_status_t.
module bgpw_ctrl
  import bgpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_kind,
  output logic       item_stall,
  input  dp_status_t st,
  output dp_cmd_t    ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;
  logic       step_ok;

  assign item_stall = (state != ST_IDLE);
  assign take       = item_valid && (state == ST_IDLE);
  // a new hit can only be held once the previous pending write has gone out
  assign step_ok    = !(st.hit && st.pend_valid && !st.can_push);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        ctl.load       = take && (item_kind == KIND_DRAW);
        ctl.set_cursor = take && (item_kind == KIND_CURSOR);
        if (ctl.load && !st.in_width_zero) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.advance = step_ok;
        ctl.capture = st.hit && step_ok;
        ctl.push    = st.hit && st.pend_valid && st.can_push;
        if (step_ok && st.at_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ctl.push_last = st.pend_valid && st.can_push;
        if (!st.pend_valid || st.can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/bgpw_dp.sv
// Datapath of the bitmap glyph pixel writer: cursor, glyph scan, pending and output registers.
// Depends on bgpw_pkg; steered by bgpw_ctrl through dp_cmd_t.
module bgpw_dp
  import bgpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_item_t         cmd,
  input  logic [COL_W-1:0]  fg_color,
  input  logic              buffer_select,
  input  dp_cmd_t           ctl,
  output dp_status_t        st,
  output logic              pix_valid,
  input  logic              pix_stall,
  output pix_item_t         pix
);

  logic [CX_W-1:0]    cursor_x;
  logic [CY_W-1:0]    cursor_y;
  logic [GLYPH_W-1:0] glyph;
  logic [WID_W-1:0]   width;
  logic [OFF_W-1:0]   row_base;
  logic [ROW_W-1:0]   row;
  logic [CIDX_W-1:0]  col;
  logic               pend_valid;
  logic [ADDR_W-1:0]  pend_addr;

  logic [WID_W-1:0]   in_width;
  logic [CX_W:0]      nx;
  logic [OFF_W-1:0]   offset;
  logic [ADDR_W-1:0]  address;
  logic               last_col;
  logic               can_push;

  assign in_width = width_lookup(cmd.char_code);
  assign nx       = {1'b0, cursor_x} + (CX_W + 1)'(in_width);
  assign offset   = row_base + OFF_W'(col);
  assign address  = ADDR_W'(offset) + (buffer_select ? ADDR_W'(FRAME_SIZE) : '0);
  assign last_col = ((WID_W)'(col) + WID_W'(1)) == width;
  assign can_push = !pix_valid || !pix_stall;

  assign st.in_width_zero = (in_width == '0);
  assign st.hit           = glyph[{~row, ~col}] && (offset < OFF_W'(FRAME_SIZE));
  assign st.at_end        = last_col && (row == ROW_W'(GLYPH_ROWS - 1));
  assign st.pend_valid    = pend_valid;
  assign st.can_push      = can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (ctl.set_cursor) begin
      cursor_x <= cmd.pos_x;
      cursor_y <= cmd.pos_y;
    end else if (ctl.load) begin
      cursor_x <= (nx > (CX_W + 1)'(CURSOR_X_MAX)) ? CX_W'(CURSOR_X_MAX) : nx[CX_W-1:0];
    end
  end

  // scan position: wrap the column at the glyph width, step the row base by one line
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      glyph    <= glyph_lookup(cmd.char_code);
      width    <= in_width;
      row      <= '0;
      col      <= '0;
      row_base <= OFF_W'(cursor_x) + OFF_W'(cursor_y) * OFF_W'(SCREEN_WIDTH);
    end else if (ctl.advance) begin
      if (last_col) begin
        col      <= '0;
        row      <= row + ROW_W'(1);
        row_base <= row_base + OFF_W'(SCREEN_WIDTH);
      end else begin
        col <= col + CIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctl.capture) begin
      pend_valid <= 1'b1;
    end else if (ctl.push_last) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      pend_addr <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (ctl.push || ctl.push_last) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.push_last) begin
      pix.address <= pend_addr;
      pix.color   <= fg_color;
      pix.last    <= ctl.push_last;
    end
  end

endmodule

### rtl/bitmap_glyph_pixel_writer.sv
// Top level of the bitmap glyph pixel writer: configuration registers and the two halves.
// Depends on bgpw_pkg, bgpw_ctrl and bgpw_dp.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one command per transfer: a cursor
//   move (kind 0) or one character to draw (kind 1) at the current cursor.
//   pix channel (pix_valid / pix_stall / pix) gives one framebuffer write per set glyph
//   pixel within the width and inside the buffer, row by row, with last set on the final write of a character.
//   APB port: fg_color at offset 0x0, buffer_select at offset 0x4; pready is always high.
//   Write the registers only while no character is in progress.
// Sequencing:
//   A cursor move gives no writes. A draw holds cmd_stall while it scans every glyph column
//   within the width on each of the 8 rows and then releases the final write; a zero-width
//   code starts no scan. The scan counter walks one pixel a cycle unless a hit waits on a
//   stalled pix write; each hit is held until the next hit or the final flush releases it.
// Stalls and reset:
//   A stalled pix write holds; the scan waits on the next hit until it can go. The output
//   register lets the next command be taken while the final write still waits.
//   Reset clears the cursor, both registers and all pending writes.
module bitmap_glyph_pixel_writer
  import bgpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_item_t          cmd,
  output logic               pix_valid,
  input  logic               pix_stall,
  output pix_item_t          pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready
);

  logic [COL_W-1:0] fg_color;
  logic             buffer_select;
  logic             reg_wr;
  dp_cmd_t          ctl;
  dp_status_t       st;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  // decode on the word address bit; byte offsets within a word are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color      <= '0;
      buffer_select <= 1'b0;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_FG_COLOR: fg_color      <= pwdata[COL_W-1:0];
        REG_BUF_SEL:  buffer_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FG_COLOR: prdata = REG_W'(fg_color);
      REG_BUF_SEL:  prdata = REG_W'(buffer_select);
      default:      prdata = '0;
    endcase
  end

  bgpw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (cmd_valid),
    .item_kind  (cmd.kind),
    .item_stall (cmd_stall),
    .st         (st),
    .ctl        (ctl)
  );

  bgpw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .fg_color      (fg_color),
    .buffer_select (buffer_select),
    .ctl           (ctl),
    .st            (st),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pix           (pix)
  );

  // nothing may stay pending once the block takes commands again
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !cmd_stall |-> !st.pend_valid)
    else $error("pending write left behind at command intake");

  a_single_push: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.push_last))
    else $error("final and non-final transfer issued together");

  a_draw_stalls: assert property (@(posedge clk) disable iff (rst)
    ctl.load && !st.in_width_zero |=> cmd_stall)
    else $error("draw with non-zero width did not start a scan");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.push || ctl.push_last) |-> (st.pend_valid && st.can_push))
    else $error("transfer issued without a pending write or free output");

endmodule

### verif/testbench.sv
// Self-checking bench for bitmap_glyph_pixel_writer: directed and random commands, with a
// predictor that holds its own font, spacing table, cursor and register copies.
// Depends on bgpw_pkg and the RTL of bitmap_glyph_pixel_writer only.
module testbench;
  import bgpw_pkg::*;

  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off that backs the block up
  localparam int SETTLE_CYCLES = 80;   // lets a blank draw finish its scan, which gives no writes
  localparam int TAIL_CYCLES   = 100;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_item_t          cmd     = '0;
  logic               pix_valid;
  logic               pix_stall = 1'b0;
  pix_item_t          pix;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [REG_W-1:0]   pwdata  = '0;
  logic [REG_W-1:0]   prdata;
  logic               pready;

  // Font rows for codes 0..127, top row in the top byte, leftmost pixel in the top bit.
  // Codes 128..255 are blank.
  logic [63:0] font [0:127] = '{
    64'h0000000000000000, 64'h7E81A581BDBD817E, 64'h7EFFDBFFC3C3FF7E, 64'h6CFEFEFE7C381000,
    64'h10387CFE7C381000, 64'h387C38FEFE10107C, 64'h00183C7EFF7E187E, 64'h0000183C3C180000,
    64'hFFFFE7C3C3E7FFFF, 64'h003C664242663C00, 64'hFFC399BDBD99C3FF, 64'h0F070F7DCCCCCC78,
    64'h3C6666663C187E18, 64'h3F333F303070F0E0, 64'h7F637F636367E6C0, 64'h995A3CE7E73C5A99,
    64'h80E0F8FEF8E08000, 64'h020E3EFE3E0E0200, 64'h183C7E18187E3C18, 64'h6666666666006600,
    64'h7FDBDB7B1B1B1B00, 64'h3F607C66663E06FC, 64'h000000007E7E7E00, 64'h183C7E187E3C18FF,
    64'h183C7E1818181800, 64'h181818187E3C1800, 64'h00180CFE0C180000, 64'h003060FE60300000,
    64'h0000C0C0C0FE0000, 64'h002466FF66240000, 64'h00183C7EFFFF0000, 64'h00FFFF7E3C180000,
    64'h0000000000000000, 64'hC0C0C0C0C000C000, 64'hD8D8D80000000000, 64'h6C6CFE6CFE6C6C00,
    64'h187EC07C06FC1800, 64'h00C6CC183066C600, 64'h386C3876DCCC7600, 64'h3030600000000000,
    64'h3060C0C0C0603000, 64'hC06030303060C000, 64'h00663CFF3C660000, 64'h003030FCFC303000,
    64'h00000000006060C0, 64'h000000FC00000000, 64'h0000000000C0C000, 64'h060C183060C08000,
    64'h7CCEDEF6E6C67C00, 64'h307030303030FC00, 64'h7CC6067CC0C0FE00, 64'hFC06063C0606FC00,
    64'h0CCCCCCCFE0C0C00, 64'hFEC0FC0606C67C00, 64'h7CC0C0FCC6C67C00, 64'hFE06060C18303000,
    64'h7CC6C67CC6C67C00, 64'h7CC6C67E06067C00, 64'h00C0C00000C0C000, 64'h00606000006060C0,
    64'h183060C060301800, 64'h0000FC00FC000000, 64'hC06030183060C000, 64'h78CC183030003000,
    64'h7CC6DEDEDEC07E00, 64'h386CC6C6FEC6C600, 64'hFCC6C6FCC6C6FC00, 64'h7CC6C0C0C0C67C00,
    64'hF8CCC6C6C6CCF800, 64'hFEC0C0F8C0C0FE00, 64'hFEC0C0F8C0C0C000, 64'h7CC6C0C0CEC67C00,
    64'hC6C6C6FEC6C6C600, 64'h7E18181818187E00, 64'h0606060606C67C00, 64'hC6CCD8F0D8CCC600,
    64'hC0C0C0C0C0C0FE00, 64'hC6EEFEFED6C6C600, 64'hC6E6F6DECEC6C600, 64'h7CC6C6C6C6C67C00,
    64'hFCC6C6FCC0C0C000, 64'h7CC6C6C6D6DE7C06, 64'hFCC6C6FCD8CCC600, 64'h7CC6C07C06C67C00,
    64'hFF18181818181800, 64'hC6C6C6C6C6C6FE00, 64'hC6C6C6C6C67C3800, 64'hC6C6C6C6D6FE6C00,
    64'hC6C66C386CC6C600, 64'hC6C6C67C1830E000, 64'hFE060C183060FE00, 64'hF0C0C0C0C0C0F000,
    64'hC06030180C060200, 64'hF03030303030F000, 64'h10386CC600000000, 64'h00000000000000FF,
    64'hC0C0600000000000, 64'h00007C067EC67E00, 64'hC0C0C0FCC6C6FC00, 64'h00007CC6C0C67C00,
    64'h0606067EC6C67E00, 64'h00007CC6FEC07C00, 64'h1C36307830307800, 64'h00007EC6C67E06FC,
    64'hC0C0FCC6C6C6C600, 64'h6000E0606060F000, 64'h060006060606C67C, 64'hC0C0CCD8F8CCC600,
    64'hE06060606060F000, 64'h0000CCFEFED6D600, 64'h0000FCC6C6C6C600, 64'h00007CC6C6C67C00,
    64'h0000FCC6C6FCC0C0, 64'h00007EC6C67E0606, 64'h0000FCC6C0C0C000, 64'h00007EC07C06FC00,
    64'h3030FC3030301C00, 64'h0000C6C6C6C67E00, 64'h0000C6C6C67C3800, 64'h0000C6C6D6FE6C00,
    64'h0000C66C386CC600, 64'h0000C6C6C67E06FC, 64'h0000FE0C3860FE00, 64'h1C3030E030301C00,
    64'hC0C0C000C0C0C000, 64'hE030301C3030E000, 64'h76DC000000000000, 64'h0010386CC6C6FE00
  };

  // Own copy of the block state and registers
  logic [CX_W-1:0]  cur_x = '0;
  logic [CY_W-1:0]  cur_y = '0;
  logic [COL_W-1:0] fg    = '0;
  logic             bsel  = 1'b0;

  pix_item_t pending_writes [$];

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int hold_request  = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int n_draws = 0, n_moves = 0, n_pixels = 0, n_errors = 0;

  bitmap_glyph_pixel_writer DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Advance of the cursor per code: 8 by default, narrower for punctuation, space, code 13,
  // the digit 1 and a few letters, none at all from 160 upwards.
  function automatic logic [WID_W-1:0] glyph_width(input logic [CODE_W-1:0] code);
    logic [WID_W-1:0] w;
    case (code)
      8'd13: w = 4'd2;
      8'd32, 8'd46, 8'd58, 8'd124: w = 4'd3;
      8'd33, 8'd44, 8'd59, 8'd96: w = 4'd4;
      8'd39, 8'd40, 8'd41, 8'd91, 8'd93, 8'd105, 8'd108: w = 4'd5;
      8'd34, 8'd60, 8'd62: w = 4'd6;
      8'd43, 8'd45, 8'd49, 8'd61, 8'd63, 8'd116, 8'd123, 8'd125: w = 4'd7;
      default: w = (code >= 8'd160) ? 4'd0 : 4'd8;
    endcase
    return w;
  endfunction

  // Work out the framebuffer writes of one command and queue them in scan order.
  // Each hit is held back one step so that the final surviving write gets the last mark.
  task automatic rasterise_cmd(input cmd_item_t c);
    logic [WID_W-1:0] w;
    logic [63:0]      g;
    int unsigned      off;
    int unsigned      nx;
    pix_item_t        held;
    bit               have;
    if (c.kind == KIND_CURSOR) begin
      cur_x = c.pos_x;
      cur_y = c.pos_y;
      n_moves++;
    end else begin
      n_draws++;
      w    = glyph_width(c.char_code);
      g    = c.char_code[7] ? 64'd0 : font[c.char_code[6:0]];
      have = 0;
      held = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int k = 0; k < GLYPH_COLS; k++) begin
          if (k < w && g[63 - 8*r - k]) begin
            // linear offset: columns past the right edge spill onto the next row
            off = int'(cur_x) + k + SCREEN_WIDTH * (int'(cur_y) + r);
            if (off < FRAME_SIZE) begin
              if (have) pending_writes.push_back(held);
              held.address = ADDR_W'(off + (bsel ? FRAME_SIZE : 0));
              held.color   = fg;
              held.last    = 1'b0;
              have         = 1;
            end
          end
        end
      end
      if (have) begin
        held.last = 1'b1;
        pending_writes.push_back(held);
      end
      nx    = int'(cur_x) + w;
      cur_x = (nx > CURSOR_X_MAX) ? CX_W'(CURSOR_X_MAX) : CX_W'(nx);
    end
  endtask

  // Predict on every command transfer and check every pixel transfer against the oldest
  // expected write. Both are sampled at the same edge, before any new drive lands.
  always @(posedge clk) begin : monitor
    pix_item_t want;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) rasterise_cmd(cmd);
      if (pix_valid && !pix_stall) begin
        n_pixels++;
        if (pending_writes.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected write: addr=%0d colour=%0d last=%0b",
                   $time, pix.address, pix.color, pix.last);
        end else begin
          want = pending_writes.pop_front();
          if (pix.address !== want.address || pix.color !== want.color ||
              pix.last !== want.last) begin
            n_errors++;
            $display("%0t: write mismatch: expected addr=%0d colour=%0d last=%0b, got addr=%0d colour=%0d last=%0b",
                     $time, want.address, want.color, want.last,
                     pix.address, pix.color, pix.last);
          end
        end
      end
    end
  end

  // Receiver: random stall at the current rate, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left   <= HOLD_CYCLES - 1;
      pix_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Offer one command and hold it until its transfer. Valid stays high afterwards so that
  // a following command goes back to back; anything that waits must drop it first.
  task automatic send_cmd(input cmd_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic send_move(input int x, input int y);
    cmd_item_t c;
    c           = $bits(cmd_item_t)'($urandom);
    c.kind      = KIND_CURSOR;
    c.pos_x     = CX_W'(x);
    c.pos_y     = CY_W'(y);
    send_cmd(c);
  endtask

  task automatic send_draw(input int code);
    cmd_item_t c;
    c           = $bits(cmd_item_t)'($urandom);
    c.kind      = KIND_DRAW;
    c.char_code = CODE_W'(code);
    send_cmd(c);
  endtask

  // Mostly printable text at on-screen positions; some control codes, upper codes and
  // off-screen cursor positions as noise.
  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int        pick;
    c    = $bits(cmd_item_t)'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      c.kind = KIND_CURSOR;
      if (pick < 14) begin
        c.pos_x = CX_W'($urandom_range(SCREEN_WIDTH - 1));
        c.pos_y = CY_W'($urandom_range(SCREEN_HEIGHT - 1));
      end
    end else begin
      c.kind = KIND_DRAW;
      if (pick < 86) c.char_code = CODE_W'($urandom_range(126, 32));
      else if (pick < 93) c.char_code = CODE_W'($urandom_range(31));
    end
    return c;
  endfunction

  // Drop valid and wait until every expected write has arrived.
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
    // a blank draw can still be scanning once the queue is empty: let it finish
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FG_COLOR) fg = value[COL_W-1:0];
    else bsel = value[0];
  endtask

  task automatic set_config(input int colour, input int buf_sel);
    write_reg(REG_FG_COLOR, REG_W'(colour));
    write_reg(REG_BUF_SEL, REG_W'(buf_sel));
  endtask

  // Edge cases in the first buffer: blank and zero-width codes, narrow glyphs, wrap past
  // the right edge, cursor saturation, bottom clipping and a cursor far off the buffer.
  task automatic test_directed();
    send_idle_pct = 12;
    rcv_idle_pct  = 52;
    set_config(0, 0);
    send_move(0, 0);
    send_draw(8);      // mostly filled glyph, 52 writes
    send_draw(0);      // blank, advance 8
    send_draw(13);     // width 2
    send_draw(32);     // space, advance 3
    send_draw(255);    // zero width, no advance
    send_draw(128);    // blank upper code, advance 8
    send_draw(160);
    send_move(316, 10);
    send_draw(87);     // right half spills onto the next row
    send_move(1016, 0);
    send_draw(65);     // cursor saturates at its limit
    send_draw(8);
    send_move(0, 236);
    send_draw(8);      // lower four rows clipped
    send_move(1023, 255);
    send_draw(8);      // everything clipped
    send_move(0, 239);
    send_draw(95);     // only the bottom row is set, and it is clipped
    send_draw(127);
    send_move(10'h2AA, 8'h55);
    send_move(10'h155, 8'hAA);
    send_draw(126);
    send_draw(124);
  endtask

  // Second buffer at full colour, up to the highest address it has.
  task automatic test_second_buffer();
    set_config(255, 1);
    send_move(0, 0);
    send_draw(1);
    send_move(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    send_draw(8);      // a single write at the last pixel of the buffer
  endtask

  task automatic test_random_stream(input int count, input int send_pct, input int rcv_pct);
    set_config($urandom_range(255), $urandom_range(1));
    send_idle_pct = send_pct;
    rcv_idle_pct  = rcv_pct;
    repeat (count) send_cmd(random_cmd());
  endtask

  // Hold the output off for a long stretch while mostly filled glyphs keep coming, so the block
  // fills up and stalls its command input.
  task automatic test_output_holdoff();
    set_config(8'h5A, 1);
    send_idle_pct = 0;
    rcv_idle_pct  = 30;
    hold_request  = hold_request + 1;
    send_move(40, 120);
    repeat (6) send_draw(8);
  endtask

  // Pause the sender until all writes are out, then pick up again.
  task automatic test_sender_pause();
    send_idle_pct = 0;
    rcv_idle_pct  = 20;
    repeat (3) begin
      repeat (6) send_cmd(random_cmd());
      wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_second_buffer();
    test_random_stream(25, 12, 52);
    test_random_stream(25, 52, 12);
    test_random_stream(25, 0, 0);
    test_output_holdoff();
    test_sender_pause();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d draws and %0d cursor moves, %0d pixel writes checked,",
             n_draws, n_moves, n_pixels);
    $display("both buffers, colours 0 and 255, and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
